@@ sv/ltvs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltvs_pkg: shared types and constants for the LRU timestamp victim selector
// Field widths, operation codes, controller state, command and status words.
// ----------------------------------------------------------------------------
package ltvs_pkg;

   localparam int SET_IDX_W  = 6;
   localparam int WAY_IDX_W  = 4;
   localparam int STAMP_W    = 64;
   localparam int MASK_W     = 8;
   localparam int VICTIM_W   = 3;

   localparam int NUM_SETS_DEF = 64;
   localparam int NUM_WAYS_DEF = 8;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_PICK   = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_REDUCE,
      ST_DELIVER
   } ltvs_state_type;

   typedef struct packed {
      logic clear_wr;   // write a zero row during the clearing pass
      logic capture;    // latch the incoming word
      logic rd_en;      // read the addressed set row
      logic upd_wr;     // write back the merged row
      logic load_cand;  // load candidates from the row just read
      logic reduce;     // one level of the min tree
      logic deliver;    // move the winner into the output register
   } ltvs_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic level_last;
      logic out_free;
      logic req_is_pick;
      logic req_upd_ok;
      logic op_pick;
   } ltvs_status_type;

endpackage

@@ sv/ltvs_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltvs_req_if: request channel
// Valid/ready channel carrying update and pick words.
// ----------------------------------------------------------------------------
interface ltvs_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 op;
   logic [ltvs_pkg::SET_IDX_W-1:0]       set_index;
   logic signed [ltvs_pkg::WAY_IDX_W-1:0] way_index;
   logic [ltvs_pkg::STAMP_W-1:0]         access_stamp;
   logic [ltvs_pkg::MASK_W-1:0]          allowed_mask;

   modport source (
      output valid, op, set_index, way_index, access_stamp, allowed_mask,
      input  ready
   );
   modport sink (
      input  valid, op, set_index, way_index, access_stamp, allowed_mask,
      output ready
   );
endinterface

@@ sv/ltvs_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltvs_rsp_if: response channel
// Valid/ready channel carrying the chosen victim way.
// ----------------------------------------------------------------------------
interface ltvs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ltvs_pkg::VICTIM_W-1:0] victim_way;
   logic                          mask_was_empty;

   modport source (
      output valid, victim_way, mask_was_empty,
      input  ready
   );
   modport sink (
      input  valid, victim_way, mask_was_empty,
      output ready
   );
endinterface

@@ sv/ltvs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltvs_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ltvs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/ltvs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltvs_ctrl: sequencing controller
// Clearing pass, request intake, row read/write-back and min-tree steps.
// ----------------------------------------------------------------------------
module ltvs_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  ltvs_pkg::ltvs_status_type status,
   output ltvs_pkg::ltvs_cmd_type    cmd
);

   ltvs_pkg::ltvs_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ltvs_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ltvs_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ltvs_pkg::ST_IDLE;
            end
         end
         ltvs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               // an update to no way is swallowed here
               if (status.req_is_pick || status.req_upd_ok) begin
                  cmd.rd_en = 1'b1;
                  state_in  = ltvs_pkg::ST_FETCH;
               end
            end
         end
         ltvs_pkg::ST_FETCH: begin
            if (status.op_pick) begin
               cmd.load_cand = 1'b1;
               state_in      = ltvs_pkg::ST_REDUCE;
            end else begin
               cmd.upd_wr = 1'b1;
               state_in   = ltvs_pkg::ST_IDLE;
            end
         end
         ltvs_pkg::ST_REDUCE: begin
            cmd.reduce = 1'b1;
            if (status.level_last) begin
               state_in = ltvs_pkg::ST_DELIVER;
            end
         end
         ltvs_pkg::ST_DELIVER: begin
            if (status.out_free) begin
               cmd.deliver = 1'b1;
               state_in    = ltvs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ltvs_pkg::ST_CLEAR;
         end
      endcase
   end

`ifndef SYNTH
   // no word may be taken in the cycle right after reset: clearing pass runs
   a_no_intake_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request taken before clearing pass");
`endif

endmodule

@@ sv/ltvs_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltvs_dp: datapath
// Stamp row store, row merge, registered min tree and output register.
// ----------------------------------------------------------------------------
module ltvs_dp #(
   parameter int NUM_SETS = ltvs_pkg::NUM_SETS_DEF,
   parameter int NUM_WAYS = ltvs_pkg::NUM_WAYS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ltvs_pkg::ltvs_cmd_type                cmd,
   output ltvs_pkg::ltvs_status_type             status,
   input  logic                                  req_op,
   input  logic [ltvs_pkg::SET_IDX_W-1:0]        req_set_index,
   input  logic signed [ltvs_pkg::WAY_IDX_W-1:0] req_way_index,
   input  logic [ltvs_pkg::STAMP_W-1:0]          req_access_stamp,
   input  logic [ltvs_pkg::MASK_W-1:0]           req_allowed_mask,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [ltvs_pkg::VICTIM_W-1:0]         rsp_victim_way,
   output logic                                  rsp_mask_was_empty
);

   localparam int SET_AW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_AW    = $clog2(NUM_WAYS);
   localparam int WAY_SLOTS = 1 << WAY_AW;
   localparam int LVL_W     = $clog2(WAY_AW + 1);
   localparam int ROW_W     = NUM_WAYS * ltvs_pkg::STAMP_W;
   localparam int SET_SPAN  = 1 << ltvs_pkg::SET_IDX_W;
   localparam int USE_W     = (NUM_WAYS < ltvs_pkg::MASK_W) ? NUM_WAYS : ltvs_pkg::MASK_W;
   localparam int UPD_W     = ltvs_pkg::WAY_IDX_W - 1;

   // set index wrap, constant table
   logic [SET_AW-1:0] wrap_lut [SET_SPAN];
   for (genvar g = 0; g < SET_SPAN; g++) begin : g_wrap
      assign wrap_lut[g] = SET_AW'(g % NUM_SETS);
   end

   // captured word
   logic                              op_ff;
   logic [SET_AW-1:0]                 addr_ff;
   logic [UPD_W-1:0]                  upd_way_ff;
   logic [ltvs_pkg::STAMP_W-1:0]      stamp_ff;
   logic [NUM_WAYS-1:0]               sel_ff;
   logic                              empty_ff;

   logic [NUM_WAYS-1:0]               usable;
   logic [SET_AW-1:0]                 clear_cnt_ff;
   logic [LVL_W-1:0]                  lvl_ff;

   logic [ROW_W-1:0]                  rd_row;
   logic [ROW_W-1:0]                  merged;
   logic [ROW_W-1:0]                  wr_row;
   logic [SET_AW-1:0]                 wr_addr;

   logic [ltvs_pkg::STAMP_W-1:0]      cand_stamp_ff [WAY_SLOTS];
   logic [WAY_AW-1:0]                 cand_way_ff   [WAY_SLOTS];
   logic [WAY_SLOTS-1:0]              cand_valid_ff;

   logic                              rsp_valid_ff;
   logic [ltvs_pkg::VICTIM_W-1:0]     rsp_way_ff;
   logic                              rsp_empty_ff;

   // mask bits past the last way are dropped
   always_comb begin
      usable = '0;
      for (int i = 0; i < USE_W; i++) begin
         usable[i] = req_allowed_mask[i];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_op;
         addr_ff    <= wrap_lut[req_set_index];
         upd_way_ff <= req_way_index[UPD_W-1:0];
         stamp_ff   <= req_access_stamp;
         sel_ff     <= (usable == '0) ? '1 : usable;
         empty_ff   <= (usable == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else if (cmd.clear_wr) begin
         clear_cnt_ff <= clear_cnt_ff + SET_AW'(1);
      end
   end

   // row merge for an update
   always_comb begin
      merged = rd_row;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (int'(upd_way_ff) == w) begin
            merged[w*ltvs_pkg::STAMP_W +: ltvs_pkg::STAMP_W] = stamp_ff;
         end
      end
   end

   assign wr_row  = cmd.clear_wr ? '0 : merged;
   assign wr_addr = cmd.clear_wr ? clear_cnt_ff : addr_ff;

   ltvs_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_SETS)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (cmd.clear_wr | cmd.upd_wr),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_en   (cmd.rd_en),
      .rd_addr (wrap_lut[req_set_index]),
      .rd_data (rd_row)
   );

   // min tree, one level a cycle, reduced in place towards slot 0
   always_ff @(posedge clock) begin
      if (cmd.load_cand) begin
         for (int i = 0; i < WAY_SLOTS; i++) begin
            if (i < NUM_WAYS) begin
               cand_stamp_ff[i] <= rd_row[i*ltvs_pkg::STAMP_W +: ltvs_pkg::STAMP_W];
               cand_way_ff[i]   <= WAY_AW'(i);
               cand_valid_ff[i] <= sel_ff[i];
            end else begin
               cand_stamp_ff[i] <= '0;
               cand_way_ff[i]   <= '0;
               cand_valid_ff[i] <= 1'b0;
            end
         end
      end else if (cmd.reduce) begin
         for (int i = 0; i < WAY_SLOTS / 2; i++) begin
            // lower slot of each pair wins ties
            if (cand_valid_ff[2*i] && (!cand_valid_ff[2*i+1] ||
                cand_stamp_ff[2*i] <= cand_stamp_ff[2*i+1])) begin
               cand_stamp_ff[i] <= cand_stamp_ff[2*i];
               cand_way_ff[i]   <= cand_way_ff[2*i];
               cand_valid_ff[i] <= 1'b1;
            end else begin
               cand_stamp_ff[i] <= cand_stamp_ff[2*i+1];
               cand_way_ff[i]   <= cand_way_ff[2*i+1];
               cand_valid_ff[i] <= cand_valid_ff[2*i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_ff <= '0;
      end else if (cmd.load_cand) begin
         lvl_ff <= '0;
      end else if (cmd.reduce) begin
         lvl_ff <= lvl_ff + LVL_W'(1);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.deliver) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.deliver) begin
         rsp_way_ff   <= ltvs_pkg::VICTIM_W'(cand_way_ff[0]);
         rsp_empty_ff <= empty_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_victim_way     = rsp_way_ff;
   assign rsp_mask_was_empty = rsp_empty_ff;

   always_comb begin
      status             = '0;
      status.clear_last  = (clear_cnt_ff == SET_AW'(NUM_SETS - 1));
      status.level_last  = (lvl_ff == LVL_W'(WAY_AW - 1));
      status.out_free    = !rsp_valid_ff || rsp_ready;
      status.req_is_pick = (req_op == ltvs_pkg::OP_PICK);
      status.req_upd_ok  = (req_op == ltvs_pkg::OP_UPDATE) &&
                           !req_way_index[ltvs_pkg::WAY_IDX_W-1] &&
                           (int'(req_way_index[UPD_W-1:0]) < NUM_WAYS);
      status.op_pick     = (op_ff == ltvs_pkg::OP_PICK);
   end

`ifndef SYNTH
   a_winner_found: assert property (@(posedge clock) disable iff (reset)
      cmd.deliver |-> cand_valid_ff[0])
      else $error("min tree delivered no candidate");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.deliver |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten before taken");

   a_upd_way_range: assert property (@(posedge clock) disable iff (reset)
      cmd.upd_wr |-> (int'(upd_way_ff) < NUM_WAYS) && (op_ff == ltvs_pkg::OP_UPDATE))
      else $error("write-back to a way outside the set");
`endif

endmodule

@@ sv/lru_timestamp_victim_select.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_timestamp_victim_select: timestamp-based LRU victim selection
// Sequencing: an update reads the set row, then writes the merged row back; an
//   update to no way is absorbed at intake.
// A pick reads the row, loads the candidates, reduces them one tree level a cycle
//   and delivers once the output register is free; then the next word is taken.
// Rate is set by the single row-wide stamp RAM and the one-level-a-cycle min tree.
// Reset: synchronous; a clearing pass then zeroes one set row per cycle over all
//   NUM_SETS rows, with req ready held low until it completes.
// ----------------------------------------------------------------------------
module lru_timestamp_victim_select #(
   parameter int NUM_SETS = ltvs_pkg::NUM_SETS_DEF,
   parameter int NUM_WAYS = ltvs_pkg::NUM_WAYS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ltvs_req_if.sink    req_bus,
   ltvs_rsp_if.source  rsp_bus
);

   // Each set is one RAM row holding all of its way stamps side by side, so a
   // pick reads a whole set in one access. Updates read-modify-write the row.
   // Set indices of NUM_SETS and above wrap through a constant table; mask bits beyond the
   // ways are dropped, and an empty mask falls back to every way.

   ltvs_pkg::ltvs_cmd_type    cmd;
   ltvs_pkg::ltvs_status_type status;

   ltvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: stamp store, min tree, output register
   ltvs_dp #(
      .NUM_SETS (NUM_SETS),
      .NUM_WAYS (NUM_WAYS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_op             (req_bus.op),
      .req_set_index      (req_bus.set_index),
      .req_way_index      (req_bus.way_index),
      .req_access_stamp   (req_bus.access_stamp),
      .req_allowed_mask   (req_bus.allowed_mask),
      .rsp_ready          (rsp_bus.ready),
      .rsp_valid          (rsp_bus.valid),
      .rsp_victim_way     (rsp_bus.victim_way),
      .rsp_mask_was_empty (rsp_bus.mask_was_empty)
   );

endmodule
